// ----- src/tlwc_pkg.sv -----
// Shared types, character codes and defaults for the letter/word/clause counter.
package tlwc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  // Item kinds on the func field
  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // ASCII codes used by the classifier
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  typedef struct packed {
    logic letter;
    logic blank;
    logic digit;
    logic apos;
    logic stop;
  } char_class_t;

endpackage

// ----- src/tlwc_classify.sv -----
// Byte classifier: letter, whitespace, digit, apostrophe, sentence stop.
module tlwc_classify (
  input  logic [7:0]           char_code,
  output tlwc_pkg::char_class_t cls
);

  always_comb begin
    cls.letter = ((char_code >= tlwc_pkg::CH_UP_A) && (char_code <= tlwc_pkg::CH_UP_Z)) ||
                 ((char_code >= tlwc_pkg::CH_LO_A) && (char_code <= tlwc_pkg::CH_LO_Z));
    cls.blank  = (char_code == tlwc_pkg::CH_SPACE) ||
                 ((char_code >= tlwc_pkg::CH_TAB) && (char_code <= tlwc_pkg::CH_CR));
    cls.digit  = (char_code >= tlwc_pkg::CH_DIG_0) && (char_code <= tlwc_pkg::CH_DIG_9);
    cls.apos   = (char_code == tlwc_pkg::CH_APOS);
    cls.stop   = (char_code == tlwc_pkg::CH_PERIOD) || (char_code == tlwc_pkg::CH_BANG) ||
                 (char_code == tlwc_pkg::CH_QUEST);
  end

endmodule

// ----- src/tlwc_counter.sv -----
// Running counters and word/clause flags, with the end-of-text totals.
module tlwc_counter #(
  parameter int unsigned COUNT_BITS = tlwc_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  func,
  input  tlwc_pkg::char_class_t cls,
  output logic [COUNT_BITS-1:0] letter_total,
  output logic [COUNT_BITS-1:0] word_total,
  output logic [COUNT_BITS-1:0] clause_total,
  output logic                  is_main_clause
);

  logic [COUNT_BITS-1:0] letters_r, letters_nxt;
  logic [COUNT_BITS-1:0] words_r, words_nxt;
  logic [COUNT_BITS-1:0] clauses_r, clauses_nxt;
  logic                  word_open_r, word_open_nxt;
  logic                  clause_open_r, clause_open_nxt;

  logic [COUNT_BITS-1:0] letters_inc, words_inc, clauses_inc;

  // hold at all-ones instead of wrapping
  assign letters_inc = (&letters_r) ? letters_r : letters_r + COUNT_BITS'(1);
  assign words_inc   = (&words_r)   ? words_r   : words_r + COUNT_BITS'(1);
  assign clauses_inc = (&clauses_r) ? clauses_r : clauses_r + COUNT_BITS'(1);

  assign letter_total   = letters_r;
  assign word_total     = words_r;
  assign clause_total   = clause_open_r ? clauses_inc : clauses_r;
  assign is_main_clause = (clause_total == COUNT_BITS'(1));

  always_comb begin
    letters_nxt     = letters_r;
    words_nxt       = words_r;
    clauses_nxt     = clauses_r;
    word_open_nxt   = word_open_r;
    clause_open_nxt = clause_open_r;
    if (step) begin
      if (func == tlwc_pkg::FUNC_END) begin
        letters_nxt     = '0;
        words_nxt       = '0;
        clauses_nxt     = '0;
        word_open_nxt   = 1'b0;
        clause_open_nxt = 1'b0;
      end else if (cls.letter) begin
        letters_nxt = letters_inc;
        if (!word_open_r) begin
          words_nxt     = words_inc;
          word_open_nxt = 1'b1;
        end
        clause_open_nxt = 1'b1;
      end else if (clause_open_r && cls.stop) begin
        // stop closes the clause but leaves the word open
        clauses_nxt     = clauses_inc;
        clause_open_nxt = 1'b0;
      end else begin
        word_open_nxt = 1'b0;
        if (!cls.blank && (cls.digit || cls.apos)) begin
          clause_open_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letters_r     <= '0;
      words_r       <= '0;
      clauses_r     <= '0;
      word_open_r   <= 1'b0;
      clause_open_r <= 1'b0;
    end else begin
      letters_r     <= letters_nxt;
      words_r       <= words_nxt;
      clauses_r     <= clauses_nxt;
      word_open_r   <= word_open_nxt;
      clause_open_r <= clause_open_nxt;
    end
  end

endmodule

// ----- src/text_letter_word_clause_counter_unit.sv -----
// Letter, word and clause counter top level: input register, counters, result register.
//
// Input channel (in_valid/in_ready): one item per byte of text with in_func = 0,
// then one item with in_func = 1 to end the text. Character items give no result.
// Result channel (out_valid/out_ready): one item per end of text, carrying the
// letter, word and clause totals and a flag set when exactly one clause was seen.
// Counters saturate at all ones. After the end-of-text item the counters clear
// and the next byte starts a new text.
// An end-of-text item passes through the input register, then the result register.
// Throughput: one item per cycle while no end-of-text item waits for a free result
// slot; the counter update is a single add and compare per counter between the
// input register and the state registers.
// Stall: while a result waits, character items keep flowing; a second
// end-of-text item waits in the input register until the result is taken,
// and in_ready drops only then.
// Reset (rst_n low, synchronous): both registers empty, all counters zero.
module text_letter_word_clause_counter_unit #(
  parameter int unsigned COUNT_BITS = tlwc_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [7:0]            in_char_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_BITS-1:0] out_letter_total,
  output logic [COUNT_BITS-1:0] out_word_total,
  output logic [COUNT_BITS-1:0] out_clause_total,
  output logic                  out_is_main_clause
);

  logic                  in_vld_r, in_vld_nxt;
  logic                  func_r;
  logic [7:0]            char_r;
  logic                  out_vld_r, out_vld_nxt;
  logic [COUNT_BITS-1:0] letter_r, word_r, clause_r;
  logic                  main_r;

  logic                  advance;
  logic                  in_take;
  logic                  emit;
  tlwc_pkg::char_class_t cls;
  logic [COUNT_BITS-1:0] letter_tot, word_tot, clause_tot;
  logic                  main_tot;

  // a character item never waits; an end-of-text item needs a free result slot
  assign advance  = in_vld_r && ((func_r == tlwc_pkg::FUNC_CHAR) || !out_vld_r || out_ready);
  assign emit     = advance && (func_r == tlwc_pkg::FUNC_END);
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  tlwc_classify u_classify (
    .char_code (char_r),
    .cls       (cls)
  );

  tlwc_counter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_counter (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .func           (func_r),
    .cls            (cls),
    .letter_total   (letter_tot),
    .word_total     (word_tot),
    .clause_total   (clause_tot),
    .is_main_clause (main_tot)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_func;
      char_r <= in_char_code;
    end
    if (emit) begin
      letter_r <= letter_tot;
      word_r   <= word_tot;
      clause_r <= clause_tot;
      main_r   <= main_tot;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_letter_total   = letter_r;
  assign out_word_total     = word_r;
  assign out_clause_total   = clause_r;
  assign out_is_main_clause = main_r;

`ifndef ASSERT_OFF
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid)
    else $error("end-of-text item did not reach the result register");

  a_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (letter_tot == '0) && (word_tot == '0) && (clause_tot == '0))
    else $error("counters not cleared after end of text");

  a_main_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_main_clause == (out_clause_total == COUNT_BITS'(1))))
    else $error("main-clause flag disagrees with clause total");

  a_words_le_letters: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_total <= out_letter_total))
    else $error("more words than letters");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for the letter, word and clause counter: queued texts, in-bench predictor, scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW          = tlwc_pkg::COUNT_BITS_DEF;
  localparam int unsigned LONG_UNITS  = 40;
  localparam int unsigned RAND_ITEMS  = 1500;
  localparam int unsigned SETTLE      = 20;
  localparam int          CYCLE_LIMIT = 50_000;

  typedef struct packed {
    logic       func;
    logic [7:0] code;
    logic       drain;
  } text_item_t;

  typedef struct packed {
    logic [CW-1:0] letters;
    logic [CW-1:0] words;
    logic [CW-1:0] clauses;
    logic          main;
  } totals_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_func = tlwc_pkg::FUNC_CHAR;
  logic [7:0]    in_char_code = 8'h00;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [CW-1:0] out_letter_total;
  logic [CW-1:0] out_word_total;
  logic [CW-1:0] out_clause_total;
  logic          out_is_main_clause;

  text_item_t feed_q[$];
  totals_t    totals_due[$];

  // predictor state
  logic [CW-1:0] n_letters = '0;
  logic [CW-1:0] n_words = '0;
  logic [CW-1:0] n_clauses = '0;
  logic          word_on = 1'b0;
  logic          clause_on = 1'b0;

  int   cycle_cnt = 0;
  int   taken_cnt = 0;
  int   chars_fed = 0;
  int   texts_done = 0;
  int   sat_seen = 0;
  int   mismatches = 0;
  int   stray = 0;
  int   calm_lo = 0;
  int   calm_hi = 0;
  logic in_took = 1'b0;

  wire calm = (taken_cnt >= calm_lo) && (taken_cnt < calm_hi);

  text_letter_word_clause_counter_unit #(.COUNT_BITS(CW)) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_letter_total   (out_letter_total),
    .out_word_total     (out_word_total),
    .out_clause_total   (out_clause_total),
    .out_is_main_clause (out_is_main_clause)
  );

  always #1 clk = ~clk;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= tlwc_pkg::CH_UP_A && c <= tlwc_pkg::CH_UP_Z) ||
           (c >= tlwc_pkg::CH_LO_A && c <= tlwc_pkg::CH_LO_Z);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == tlwc_pkg::CH_SPACE) || (c >= tlwc_pkg::CH_TAB && c <= tlwc_pkg::CH_CR);
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= tlwc_pkg::CH_DIG_0 && c <= tlwc_pkg::CH_DIG_9;
  endfunction

  function automatic logic [CW-1:0] bump(logic [CW-1:0] v);
    return (&v) ? v : v + CW'(1);
  endfunction

  task automatic count_item(input logic func, input logic [7:0] c);
    logic [CW-1:0] cl;
    totals_t       t;
    if (func == tlwc_pkg::FUNC_END) begin
      cl = clause_on ? bump(n_clauses) : n_clauses;
      t.letters = n_letters;
      t.words   = n_words;
      t.clauses = cl;
      t.main    = (cl == CW'(1));
      totals_due.push_back(t);
      n_letters = '0;
      n_words   = '0;
      n_clauses = '0;
      word_on   = 1'b0;
      clause_on = 1'b0;
    end else if (is_alpha(c)) begin
      n_letters = bump(n_letters);
      if (!word_on) begin
        n_words = bump(n_words);
        word_on = 1'b1;
      end
      clause_on = 1'b1;
    end else if (clause_on && (c == tlwc_pkg::CH_PERIOD || c == tlwc_pkg::CH_BANG ||
                               c == tlwc_pkg::CH_QUEST)) begin
      // a clause stop keeps the word open
      n_clauses = bump(n_clauses);
      clause_on = 1'b0;
    end else begin
      word_on = 1'b0;
      if (!is_space(c) && (is_num(c) || c == tlwc_pkg::CH_APOS)) clause_on = 1'b1;
    end
  endtask

  task automatic check_field(input string what, input logic [CW-1:0] want,
                             input logic [CW-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic push_char(input logic [7:0] c);
    feed_q.push_back('{func: tlwc_pkg::FUNC_CHAR, code: c, drain: 1'b0});
  endtask

  task automatic push_end();
    feed_q.push_back('{func: tlwc_pkg::FUNC_END, code: 8'($urandom_range(255)), drain: 1'b0});
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(99);
    if (r < 42) return 8'(tlwc_pkg::CH_UP_A + $urandom_range(25));
    if (r < 85) return 8'(tlwc_pkg::CH_LO_A + $urandom_range(25));
    if (r < 90) return 8'(tlwc_pkg::CH_DIG_0 + $urandom_range(9));
    if (r < 94) return tlwc_pkg::CH_APOS;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] gap_char();
    if ($urandom_range(99) < 80) return tlwc_pkg::CH_SPACE;
    return 8'(tlwc_pkg::CH_TAB + $urandom_range(4));
  endfunction

  function automatic logic [7:0] stop_char();
    case ($urandom_range(2))
      0: return tlwc_pkg::CH_PERIOD;
      1: return tlwc_pkg::CH_BANG;
      default: return tlwc_pkg::CH_QUEST;
    endcase
  endfunction

  // Mostly sentences with random content; some empty texts and some pure noise.
  task automatic push_text();
    int n_sent;
    int n_w;
    int n_l;
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      push_end();
      return;
    end
    if (r < 20) begin
      repeat ($urandom_range(1, 30)) push_char(8'($urandom_range(255)));
    end else begin
      n_sent = $urandom_range(1, 3);
      for (int s = 0; s < n_sent; s++) begin
        n_w = $urandom_range(1, 5);
        for (int w = 0; w < n_w; w++) begin
          n_l = $urandom_range(1, 7);
          for (int l = 0; l < n_l; l++) push_char(word_char());
          if (w < n_w - 1) push_char(gap_char());
        end
        if ($urandom_range(99) < 85) push_char(stop_char());
        if ($urandom_range(99) < 20) push_char(stop_char());
        if ($urandom_range(99) < 50) push_char(gap_char());
      end
    end
    push_end();
  endtask

  // Driver: load the next item once the current one is taken.
  always @(negedge clk) begin
    text_item_t nxt;
    logic       load;
    if (rst_n && (!in_valid || in_took)) begin
      load = (feed_q.size() != 0) && (calm || $urandom_range(99) >= 10);
      // hold a marked item until every pending result is out
      if (load && feed_q[0].drain && totals_due.size() != 0) load = 1'b0;
      if (load) begin
        nxt = feed_q.pop_front();
        in_func      <= nxt.func;
        in_char_code <= nxt.code;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= calm || ($urandom_range(99) >= 10);
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin
    totals_t want;
    cycle_cnt++;
    in_took = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (totals_due.size() == 0) begin
        mismatches++;
        if (stray < 20) $display("%0t: result with nothing expected, letters %0d words %0d",
                                 $time, out_letter_total, out_word_total);
        stray++;
      end else begin
        want = totals_due.pop_front();
        check_field("letter_total", want.letters, out_letter_total);
        check_field("word_total", want.words, out_word_total);
        check_field("clause_total", want.clauses, out_clause_total);
        check_field("is_main_clause", CW'(want.main), CW'(out_is_main_clause));
        texts_done++;
        if (&want.letters) sat_seen++;
      end
    end
    if (in_took) begin
      taken_cnt++;
      if (in_func == tlwc_pkg::FUNC_CHAR) chars_fed++;
      count_item(in_func, in_char_code);
    end
  end

  initial begin
    int rand_first;

    // empty text
    push_end();
    // stop with no clause, stop inside a word, stop after a stop, digit and apostrophe
    push_char(tlwc_pkg::CH_PERIOD);
    push_char(tlwc_pkg::CH_UP_A);
    push_char(tlwc_pkg::CH_LO_Z);
    push_char(tlwc_pkg::CH_PERIOD);
    push_char(tlwc_pkg::CH_UP_Z);
    push_char(tlwc_pkg::CH_BANG);
    push_char(tlwc_pkg::CH_QUEST);
    push_char(tlwc_pkg::CH_LO_A);
    push_char(tlwc_pkg::CH_SPACE);
    push_char(tlwc_pkg::CH_DIG_9);
    push_char(tlwc_pkg::CH_APOS);
    push_end();
    // class boundaries and byte extremes
    push_char(tlwc_pkg::CH_TAB);
    push_char(tlwc_pkg::CH_CR);
    push_char(tlwc_pkg::CH_TAB - 8'd1);
    push_char(tlwc_pkg::CH_CR + 8'd1);
    push_char(tlwc_pkg::CH_UP_A - 8'd1);
    push_char(tlwc_pkg::CH_UP_Z + 8'd1);
    push_char(tlwc_pkg::CH_LO_A - 8'd1);
    push_char(tlwc_pkg::CH_LO_Z + 8'd1);
    push_char(tlwc_pkg::CH_DIG_0 - 8'd1);
    push_char(tlwc_pkg::CH_DIG_9 + 8'd1);
    push_char(8'h00);
    push_char(8'h80);
    push_char(8'hFF);
    push_char(tlwc_pkg::CH_DIG_0);
    push_end();

    // a long run of one-letter clauses, ending on an open clause
    for (int k = 0; k < LONG_UNITS; k++) begin
      push_char(tlwc_pkg::CH_LO_A);
      push_char(tlwc_pkg::CH_PERIOD);
      push_char(tlwc_pkg::CH_SPACE);
    end
    push_char(tlwc_pkg::CH_UP_Z);
    push_end();

    rand_first = feed_q.size();
    calm_lo = rand_first + 300;
    calm_hi = calm_lo + 400;
    while (feed_q.size() - rand_first < RAND_ITEMS) push_text();
    feed_q[rand_first + 500].drain = 1'b1;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    wait (feed_q.size() == 0 && !in_valid);
    wait (totals_due.size() == 0);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d texts (%0d with saturated counts), %0d characters, %0d items.",
             texts_done, sat_seen, chars_fed, taken_cnt);
    $display("Errors found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles, %0d results still pending",
             cycle_cnt, totals_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
